@@ rtl/svr_pkg.sv @@
package svr_pkg;

  localparam int unsigned NUM_V   = 1024;
  localparam int unsigned NUM_E   = 8192;
  localparam int unsigned MAX_DEG = 32;

  localparam int unsigned V_W   = 10;  // vertex number
  localparam int unsigned E_W   = 13;  // edge index
  localparam int unsigned R_W   = 14;  // row offset value
  localparam int unsigned RA_W  = 11;  // row offset table index
  localparam int unsigned W_W   = 48;  // vertex weight
  localparam int unsigned CNT_W = 6;   // counts up to MAX_DEG + 1

  typedef enum logic [1:0] {
    FN_LD_ROW  = 2'd0,
    FN_LD_EDGE = 2'd1,
    FN_LD_VERT = 2'd2,
    FN_QUERY   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_INCLUDE = 2'd1,
    ST_EXCLUDE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    W_HOLD = 2'd0,
    W_INIT = 2'd1,
    W_ISO  = 2'd2,
    W_NB   = 2'd3
  } wop_e;

  typedef struct packed {
    wop_e           op;
    logic [W_W-1:0] w;
    logic [V_W-1:0] v;
  } wcmd_t;

  typedef struct packed {
    logic [V_W-1:0] best_node;
    logic           iso_zero;
    logic           eq_nb;
    logic           le_iso;
  } wres_t;

endpackage

@@ rtl/svr_wunit.sv @@
module svr_wunit
  import svr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  wcmd_t cmd_i,
  output wres_t res_o
);

  logic [W_W-1:0] best_iso_q, best_iso_d;
  logic [W_W-1:0] best_nb_q, best_nb_d;
  logic [V_W-1:0] best_node_q, best_node_d;
  logic           gt_iso, gt_nb;

  // Weight comparators of the command weight against the two running maxima.
  assign gt_iso = cmd_i.w > best_iso_q;
  assign gt_nb  = cmd_i.w > best_nb_q;

  always_comb begin
    best_iso_d  = best_iso_q;
    best_nb_d   = best_nb_q;
    best_node_d = best_node_q;
    case (cmd_i.op)
      W_INIT: begin
        best_iso_d  = cmd_i.w;
        best_node_d = (cmd_i.w == '0) ? '0 : cmd_i.v;
        best_nb_d   = '0;
      end
      W_ISO: begin
        if (gt_iso) begin
          best_iso_d  = cmd_i.w;
          best_node_d = cmd_i.v;
        end
      end
      W_NB: begin
        if (gt_nb) begin
          best_nb_d = cmd_i.w;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_iso_q  <= '0;
      best_nb_q   <= '0;
      best_node_q <= '0;
    end else begin
      best_iso_q  <= best_iso_d;
      best_nb_q   <= best_nb_d;
      best_node_q <= best_node_d;
    end
  end

  assign res_o.best_node = best_node_q;
  assign res_o.iso_zero  = (best_iso_q == '0);
  assign res_o.eq_nb     = (best_iso_q == best_nb_q);
  assign res_o.le_iso    = !gt_iso;

endmodule

@@ rtl/simplicial_vertex_reduction.sv @@
// Simplicial-vertex reduction engine for a graph held in CSR form.
// The slave stream carries one transaction per item: tuser selects the kind
// (row offset load, edge target load, vertex weight and active flag load,
// or query), and tdata carries the operands. Loads produce no output. A
// query names a vertex and yields one to 32 output transactions on the
// master stream, the final one flagged by tlast; tuser carries the status
// (none, include or exclude) and tdata the vertex.
// The block works on one query at a time and is not ready while doing so.
// An inactive or over-long query vertex answers with a single none result.
// Every step goes through memories with registered read data.
// After reset the block clears the active flags and the clique marks of all
// 1024 vertices before it first asserts tready. Each result is held in
// an output register until the receiver takes it; a stalled receiver
// simply holds the sequencer, and nothing is lost.
module simplicial_vertex_reduction
  import svr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: table_index[12:0], table_value[26:13], vertex_weight[74:27],
  //        vertex_active[75], query_vertex[85:76], zero fill above
  input  logic [87:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: vertex[9:0], zero fill above
  output logic [15:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  typedef enum logic [27:0] {
    S_CLR   = 28'd1 << 0,
    S_IDLE  = 28'd1 << 1,
    S_RO0   = 28'd1 << 2,
    S_RO1   = 28'd1 << 3,
    S_RO2   = 28'd1 << 4,
    S_MK_E  = 28'd1 << 5,
    S_MK_A  = 28'd1 << 6,
    S_MK_W  = 28'd1 << 7,
    S_CK_E  = 28'd1 << 8,
    S_CK_A  = 28'd1 << 9,
    S_CK_R0 = 28'd1 << 10,
    S_CK_R1 = 28'd1 << 11,
    S_CK_JE = 28'd1 << 12,
    S_CK_JA = 28'd1 << 13,
    S_CK_JW = 28'd1 << 14,
    S_CK_END = 28'd1 << 15,
    S_CL_E  = 28'd1 << 16,
    S_CL_A  = 28'd1 << 17,
    S_P2_E  = 28'd1 << 18,
    S_P2_A  = 28'd1 << 19,
    S_P2_W  = 28'd1 << 20,
    S_DEC   = 28'd1 << 21,
    S_EM_E  = 28'd1 << 22,
    S_EM_A  = 28'd1 << 23,
    S_EM_W  = 28'd1 << 24,
    S_OUT   = 28'd1 << 25,
    S_SPARE0 = 28'd1 << 26,
    S_SPARE1 = 28'd1 << 27
  } state_e;

  // Input field views.
  func_e          in_func;
  logic [E_W-1:0] in_idx;
  logic [R_W-1:0] in_val;
  logic [W_W-1:0] in_w;
  logic           in_act;
  logic [V_W-1:0] in_q;

  assign in_func = func_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[12:0];
  assign in_val  = s_axis_tdata[26:13];
  assign in_w    = s_axis_tdata[74:27];
  assign in_act  = s_axis_tdata[75];
  assign in_q    = s_axis_tdata[85:76];

  // Memories. Edge entries hold the target and a flag for a target that is
  // not a vertex number.
  logic [R_W-1:0] ro_mem  [NUM_V+1];
  logic [V_W:0]   e_mem   [NUM_E];
  logic [W_W-1:0] wt_mem  [NUM_V];
  logic           act_mem [NUM_V];
  logic           mk_mem  [NUM_V];

  logic [RA_W-1:0] ro_ra;
  logic [E_W-1:0]  e_ra;
  logic [V_W-1:0]  wt_ra, act_ra, mk_ra;
  logic [R_W-1:0]  ro_q;
  logic [V_W:0]    e_q;
  logic [W_W-1:0]  wt_q;
  logic            act_q, mk_q;

  logic            act_we, act_wd, mk_we, mk_wd;
  logic [V_W-1:0]  act_wa, mk_wa;
  logic            ld;

  state_e          state_q, state_d;
  logic [V_W-1:0]  clr_q, clr_d;
  logic [V_W-1:0]  u_q, u_d, c_q, c_d, t_q, t_d;
  logic            toor_q, toor_d, coor_q, coor_d, uact_q, uact_d;
  logic [R_W-1:0]  lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d, jhi_q, jhi_d;
  logic [R_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0] marked_q, marked_d, nred_q, nred_d, nemit_q, nemit_d;
  logic            clique_q, clique_d, alone_q, alone_d;
  logic [W_W-1:0]  cw_q, cw_d;
  status_e         ost_q, ost_d;
  logic [V_W-1:0]  ovx_q, ovx_d;
  logic            olast_q, olast_d;

  wcmd_t           wcmd;
  wres_t           wres;

  // Row bound clamping: end limited to the edge count, start to the end.
  logic [R_W-1:0]  rb_hi, rb_src, rb_lo;
  assign rb_hi  = (ro_q > R_W'(NUM_E)) ? R_W'(NUM_E) : ro_q;
  assign rb_src = (state_q == S_RO2) ? lo_q : j_q;
  assign rb_lo  = (rb_src > rb_hi) ? rb_hi : rb_src;

  assign ld = (state_q == S_IDLE) && s_axis_tvalid;

  always_ff @(posedge clk_i) begin
    if (ld && in_func == FN_LD_ROW && in_idx <= E_W'(NUM_V)) begin
      ro_mem[in_idx[RA_W-1:0]] <= in_val;
    end
    if (ld && in_func == FN_LD_EDGE) begin
      e_mem[in_idx] <= {(in_val[R_W-1:V_W] != '0), in_val[V_W-1:0]};
    end
    if (ld && in_func == FN_LD_VERT && in_idx < E_W'(NUM_V)) begin
      wt_mem[in_idx[V_W-1:0]] <= in_w;
    end
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    if (mk_we) begin
      mk_mem[mk_wa] <= mk_wd;
    end
    ro_q  <= ro_mem[ro_ra];
    e_q   <= e_mem[e_ra];
    wt_q  <= wt_mem[wt_ra];
    act_q <= act_mem[act_ra];
    mk_q  <= mk_mem[mk_ra];
  end

  svr_wunit u_wunit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (wcmd),
    .res_o  (wres)
  );

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    u_d      = u_q;
    c_d      = c_q;
    t_d      = t_q;
    toor_d   = toor_q;
    coor_d   = coor_q;
    uact_d   = uact_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    i_d      = i_q;
    j_d      = j_q;
    jhi_d    = jhi_q;
    cnt_d    = cnt_q;
    marked_d = marked_q;
    nred_d   = nred_q;
    nemit_d  = nemit_q;
    clique_d = clique_q;
    alone_d  = alone_q;
    cw_d     = cw_q;
    ost_d    = ost_q;
    ovx_d    = ovx_q;
    olast_d  = olast_q;

    ro_ra  = '0;
    e_ra   = i_q[E_W-1:0];
    wt_ra  = t_q;
    act_ra = t_q;
    mk_ra  = t_q;
    act_we = 1'b0;
    act_wa = in_idx[V_W-1:0];
    act_wd = in_act;
    mk_we  = 1'b0;
    mk_wa  = u_q;
    mk_wd  = 1'b0;

    wcmd.op = W_HOLD;
    wcmd.w  = (state_q == S_CK_END) ? cw_q : wt_q;
    wcmd.v  = (state_q == S_CK_END) ? c_q : u_q;

    case (state_q)
      S_CLR: begin
        act_we = 1'b1;
        act_wa = clr_q;
        act_wd = 1'b0;
        mk_we  = 1'b1;
        mk_wa  = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == V_W'(NUM_V - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_func)
            FN_LD_VERT: act_we = (in_idx < E_W'(NUM_V));
            FN_QUERY: begin
              u_d     = in_q;
              state_d = S_RO0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RO0: begin
        ro_ra   = {1'b0, u_q};
        act_ra  = u_q;
        wt_ra   = u_q;
        state_d = S_RO1;
      end
      S_RO1: begin
        lo_d    = ro_q;
        uact_d  = act_q;
        wcmd.op = W_INIT;
        ro_ra   = {1'b0, u_q} + RA_W'(1);
        state_d = S_RO2;
      end
      S_RO2: begin
        lo_d = rb_lo;
        hi_d = rb_hi;
        i_d  = rb_lo;
        if (!uact_q || (rb_hi - rb_lo) > R_W'(MAX_DEG)) begin
          ost_d   = ST_NONE;
          ovx_d   = '0;
          olast_d = 1'b1;
          state_d = S_OUT;
        end else begin
          mk_we    = 1'b1;
          mk_wd    = 1'b1;
          marked_d = CNT_W'(1);
          state_d  = S_MK_E;
        end
      end
      S_MK_E: begin
        if (i_q == hi_q) begin
          i_d      = lo_q;
          clique_d = 1'b1;
          state_d  = S_CK_E;
        end else begin
          state_d = S_MK_A;
        end
      end
      S_MK_A: begin
        t_d     = e_q[V_W-1:0];
        toor_d  = e_q[V_W];
        act_ra  = e_q[V_W-1:0];
        state_d = S_MK_W;
      end
      S_MK_W: begin
        if (!toor_q && act_q) begin
          mk_we    = 1'b1;
          mk_wa    = t_q;
          mk_wd    = 1'b1;
          marked_d = marked_q + 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = S_MK_E;
      end
      S_CK_E: begin
        if (i_q == hi_q || !clique_q) begin
          mk_we   = 1'b1;
          i_d     = lo_q;
          state_d = S_CL_E;
        end else begin
          state_d = S_CK_A;
        end
      end
      S_CK_A: begin
        c_d     = e_q[V_W-1:0];
        coor_d  = e_q[V_W];
        act_ra  = e_q[V_W-1:0];
        wt_ra   = e_q[V_W-1:0];
        ro_ra   = {1'b0, e_q[V_W-1:0]};
        state_d = S_CK_R0;
      end
      S_CK_R0: begin
        if (coor_q || !act_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_CK_E;
        end else begin
          j_d     = ro_q;
          cw_d    = wt_q;
          ro_ra   = {1'b0, c_q} + RA_W'(1);
          state_d = S_CK_R1;
        end
      end
      S_CK_R1: begin
        j_d     = rb_lo;
        jhi_d   = rb_hi;
        cnt_d   = R_W'(1);
        alone_d = 1'b1;
        state_d = S_CK_JE;
      end
      S_CK_JE: begin
        e_ra = j_q[E_W-1:0];
        if (j_q == jhi_q) begin
          state_d = S_CK_END;
        end else begin
          state_d = S_CK_JA;
        end
      end
      S_CK_JA: begin
        t_d     = e_q[V_W-1:0];
        toor_d  = e_q[V_W];
        act_ra  = e_q[V_W-1:0];
        mk_ra   = e_q[V_W-1:0];
        state_d = S_CK_JW;
      end
      S_CK_JW: begin
        if (!toor_q && act_q) begin
          if (mk_q) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            alone_d = 1'b0;
          end
        end
        j_d     = j_q + 1'b1;
        state_d = S_CK_JE;
      end
      S_CK_END: begin
        if (cnt_q != R_W'(marked_q)) begin
          clique_d = 1'b0;
        end else if (alone_q) begin
          wcmd.op = W_ISO;
        end
        i_d     = i_q + 1'b1;
        state_d = S_CK_E;
      end
      S_CL_E: begin
        if (i_q == hi_q) begin
          if (!clique_q || wres.iso_zero) begin
            ost_d   = ST_NONE;
            ovx_d   = '0;
            olast_d = 1'b1;
            state_d = S_OUT;
          end else begin
            i_d     = lo_q;
            nred_d  = '0;
            nemit_d = '0;
            state_d = S_P2_E;
          end
        end else begin
          state_d = S_CL_A;
        end
      end
      S_CL_A: begin
        if (!e_q[V_W]) begin
          mk_we = 1'b1;
          mk_wa = e_q[V_W-1:0];
        end
        i_d     = i_q + 1'b1;
        state_d = S_CL_E;
      end
      S_P2_E, S_EM_E: begin
        if (state_q == S_P2_E && i_q == hi_q) begin
          state_d = S_DEC;
        end else begin
          state_d = (state_q == S_P2_E) ? S_P2_A : S_EM_A;
        end
      end
      S_P2_A, S_EM_A: begin
        t_d     = e_q[V_W-1:0];
        toor_d  = e_q[V_W];
        act_ra  = e_q[V_W-1:0];
        wt_ra   = e_q[V_W-1:0];
        state_d = (state_q == S_P2_A) ? S_P2_W : S_EM_W;
      end
      S_P2_W: begin
        if (!toor_q && act_q) begin
          wcmd.op = W_NB;
          if (wres.le_iso && t_q != wres.best_node) begin
            nred_d = nred_q + 1'b1;
          end
        end
        i_d     = i_q + 1'b1;
        state_d = S_P2_E;
      end
      S_DEC: begin
        ovx_d   = '0;
        olast_d = 1'b1;
        ost_d   = ST_NONE;
        state_d = S_OUT;
        if (wres.eq_nb) begin
          ost_d = ST_INCLUDE;
          ovx_d = wres.best_node;
        end else if (nred_q != '0) begin
          i_d     = lo_q;
          nemit_d = '0;
          state_d = S_EM_E;
        end
      end
      S_EM_W: begin
        i_d     = i_q + 1'b1;
        state_d = S_EM_E;
        if (!toor_q && act_q && wres.le_iso && t_q != wres.best_node) begin
          ost_d   = ST_EXCLUDE;
          ovx_d   = t_q;
          olast_d = (nemit_q + 1'b1 == nred_q);
          nemit_d = nemit_q + 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = olast_q ? S_IDLE : S_EM_E;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      marked_q <= '0;
      nred_q   <= '0;
      nemit_q  <= '0;
      clique_q <= 1'b0;
      alone_q  <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      marked_q <= marked_d;
      nred_q   <= nred_d;
      nemit_q  <= nemit_d;
      clique_q <= clique_d;
      alone_q  <= alone_d;
      olast_q  <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    c_q    <= c_d;
    t_q    <= t_d;
    toor_q <= toor_d;
    coor_q <= coor_d;
    uact_q <= uact_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    i_q    <= i_d;
    j_q    <= j_d;
    jhi_q  <= jhi_d;
    cnt_q  <= cnt_d;
    cw_q   <= cw_d;
    ost_q  <= ost_d;
    ovx_q  <= ovx_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, ovx_q};
  assign m_axis_tuser  = ost_q;
  assign m_axis_tlast  = olast_q;

  // The input side is never open while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input accepted while a result is pending");

  // The closed neighbourhood never counts more than the degree limit plus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    marked_q <= CNT_W'(MAX_DEG + 1))
    else $error("marked count beyond the degree limit");

  // Exclude results never outrun the count found beforehand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nemit_q <= nred_q || state_q == S_IDLE || state_q == S_CLR)
    else $error("more exclude results than counted");

  // The final result of a query returns the block to accepting items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block not ready after the final result");

endmodule
